// ===== src/wsm_pkg.sv =====
package wsm_pkg;
    localparam int MaxWindows = 16;
    localparam int SlotW = $clog2(MaxWindows);
    localparam int CntW = $clog2(MaxWindows + 1);

    typedef enum logic [2:0] {
        OP_CREATE  = 3'd0,
        OP_RAISE   = 3'd1,
        OP_FOCUS   = 3'd2,
        OP_UNFOCUS = 3'd3,
        OP_DESTROY = 3'd4,
        OP_HIT     = 3'd5
    } op_t;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_MISS = 2'd2;

    typedef struct packed {
        logic [2:0]         operation;
        logic signed [12:0] pos_x;
        logic signed [12:0] pos_y;
        logic [11:0]        width;
        logic [11:0]        height;
        logic [15:0]        window_id;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] result_id;
        logic [3:0]  stack_index;
        logic [23:0] pixel_offset;
        logic [4:0]  window_count;
        logic [15:0] focused_id;
    } res_t;
endpackage

// ===== src/window_stack_manager_core.sv =====
// window_stack_manager_core
// Input channel s_axis_*: one command item per handshake; tdata packs
// operation, pos_x, pos_y, width, height, window_id. Output channel
// m_axis_*: one result item per command.
// Commands pass a two-entry queue to a sequencing engine. Create and
// unfocus go straight to the output step; raise/focus/destroy search for
// the id, then shift one slot per cycle; a hit test checks one slot per
// cycle from the top, then takes a multiply step on a hit. The stack
// holds up to 16 windows. The engine takes one command at a time and the
// next only after the previous result has left.
// Reset clears the window count and sets the id counter to one.
// A stalled receiver holds the result register; the queue keeps taking
// up to two commands meanwhile.
module window_stack_manager_core
    import wsm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // operation[2:0] pos_x[15:3] pos_y[28:16] width[40:29] height[52:41] window_id[68:53]
    input  logic [71:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status[1:0] result_id[17:2] stack_index[21:18] pixel_offset[45:22]
    // window_count[50:46] focused_id[66:51]
    output logic [71:0] m_axis_tdata
);
    cmd_t in_cmd, q_cmd;
    logic q_valid, q_ready;
    res_t r;

    assign in_cmd.operation = s_axis_tdata[2:0];
    assign in_cmd.pos_x     = s_axis_tdata[15:3];
    assign in_cmd.pos_y     = s_axis_tdata[28:16];
    assign in_cmd.width     = s_axis_tdata[40:29];
    assign in_cmd.height    = s_axis_tdata[52:41];
    assign in_cmd.window_id = s_axis_tdata[68:53];

    wsm_cmd_fifo u_fifo (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_cmd(in_cmd),
        .out_valid(q_valid), .out_ready(q_ready), .out_cmd(q_cmd)
    );

    wsm_engine u_eng (
        .aclk(aclk), .aresetn(aresetn),
        .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
        .res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res(r)
    );

    assign m_axis_tdata = {5'd0, r.focused_id, r.window_count, r.pixel_offset,
                           r.stack_index, r.result_id, r.status};
endmodule

// ===== src/wsm_cmd_fifo.sv =====
module wsm_cmd_fifo
    import wsm_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    output logic in_ready,
    input  cmd_t in_cmd,
    output logic out_valid,
    input  logic out_ready,
    output cmd_t out_cmd
);
    cmd_t       mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign in_ready  = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_cmd   = mem_reg[rp_reg];

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            mem_reg[wp_reg] <= in_cmd;
        end
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (in_valid && in_ready) wp_reg <= ~wp_reg;
            if (out_valid && out_ready) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(in_valid && in_ready) - 2'(out_valid && out_ready);
        end
    end
endmodule

// ===== src/wsm_engine.sv =====
module wsm_engine
    import wsm_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic cmd_valid,
    output logic cmd_ready,
    input  cmd_t cmd,
    output logic res_valid,
    input  logic res_ready,
    output res_t res
);
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_FIND  = 6'b000010,
        S_SHIFT = 6'b000100,
        S_HIT   = 6'b001000,
        S_MUL   = 6'b010000,
        S_OUT   = 6'b100000
    } state_t;

    logic [15:0]        sid_reg [MaxWindows];
    logic signed [12:0] sx_reg  [MaxWindows];
    logic signed [12:0] sy_reg  [MaxWindows];
    logic [11:0]        sw_reg  [MaxWindows];
    logic [11:0]        sh_reg  [MaxWindows];
    logic [1:0]         sf_reg  [MaxWindows];

    state_t      state_reg;
    cmd_t        c_reg;
    logic [CntW-1:0] live_reg;
    logic [15:0] idc_reg;
    logic [CntW-1:0] i_reg;
    logic [SlotW-1:0] tgt_reg;
    logic [1:0]  st_reg;
    logic [15:0] rid_reg;
    logic [SlotW-1:0] hidx_reg;
    logic [11:0] dx_reg, dy_reg;
    logic [11:0] hw_reg;
    logic [23:0] offs_reg;
    logic        res_v_reg;
    res_t        res_reg;

    logic [15:0] foc_id;
    logic [SlotW-1:0] ix;
    logic signed [13:0] ex, ey;
    logic        hit;
    logic [15:0] sv_id_reg;
    logic signed [12:0] sv_x_reg, sv_y_reg;
    logic [11:0] sv_w_reg, sv_h_reg;
    logic [1:0]  sv_f_reg;

    assign ix = i_reg[SlotW-1:0];
    assign cmd_ready = (state_reg == S_IDLE) && !res_v_reg;
    assign res_valid = res_v_reg;
    assign res = res_reg;

    // focused id: first live slot with focus mark
    always_comb begin
        foc_id = 16'd0;
        for (int k = MaxWindows - 1; k >= 0; k--) begin
            if (CntW'(k) < live_reg && sf_reg[k][1]) foc_id = sid_reg[k];
        end
    end

    assign ex = 14'(sx_reg[ix]) + $signed({2'b00, sw_reg[ix]});
    assign ey = 14'(sy_reg[ix]) + $signed({2'b00, sh_reg[ix]});
    assign hit = sf_reg[ix][0] && (c_reg.pos_x >= sx_reg[ix]) && (14'(c_reg.pos_x) < ex)
              && (c_reg.pos_y >= sy_reg[ix]) && (14'(c_reg.pos_y) < ey);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            live_reg  <= '0;
            idc_reg   <= 16'd1;
            res_v_reg <= 1'b0;
        end else begin
            if (res_v_reg && res_ready) res_v_reg <= 1'b0;
            case (state_reg)
                S_IDLE: begin
                    if (cmd_valid && cmd_ready) begin
                        c_reg    <= cmd;
                        hidx_reg <= '0;
                        offs_reg <= 24'd0;
                        case (cmd.operation)
                            OP_CREATE: begin
                                i_reg <= '0;
                                if (live_reg >= CntW'(MaxWindows)) begin
                                    st_reg  <= ST_FULL;
                                    rid_reg <= 16'd0;
                                end else begin
                                    st_reg <= ST_OK;
                                    sid_reg[live_reg[SlotW-1:0]] <= idc_reg;
                                    sx_reg[live_reg[SlotW-1:0]]  <= cmd.pos_x;
                                    sy_reg[live_reg[SlotW-1:0]]  <= cmd.pos_y;
                                    sw_reg[live_reg[SlotW-1:0]]  <= cmd.width;
                                    sh_reg[live_reg[SlotW-1:0]]  <= cmd.height;
                                    sf_reg[live_reg[SlotW-1:0]]  <= 2'b01;
                                    live_reg <= live_reg + 1'b1;
                                    rid_reg  <= idc_reg;
                                    idc_reg  <= (idc_reg == 16'hFFFF) ? 16'd1
                                                                      : idc_reg + 16'd1;
                                end
                                state_reg <= S_OUT;
                            end
                            OP_RAISE, OP_FOCUS, OP_DESTROY: begin
                                st_reg    <= ST_OK;
                                rid_reg   <= 16'd0;
                                i_reg     <= '0;
                                state_reg <= S_FIND;
                            end
                            OP_UNFOCUS: begin
                                st_reg  <= ST_OK;
                                rid_reg <= 16'd0;
                                i_reg   <= '0;
                                for (int k = 0; k < MaxWindows; k++) sf_reg[k][1] <= 1'b0;
                                state_reg <= S_OUT;
                            end
                            OP_HIT: begin
                                // scan from the top slot down
                                st_reg    <= ST_MISS;
                                rid_reg   <= 16'd0;
                                i_reg     <= live_reg - 1'b1;
                                state_reg <= (live_reg == '0) ? S_OUT : S_HIT;
                            end
                            default: begin
                                st_reg    <= ST_OK;
                                rid_reg   <= 16'd0;
                                i_reg     <= '0;
                                state_reg <= S_OUT;
                            end
                        endcase
                    end
                end
                S_FIND: begin
                    if (i_reg >= live_reg) begin
                        st_reg <= ST_MISS;
                        state_reg <= S_OUT;
                    end else if (sid_reg[ix] == c_reg.window_id) begin
                        tgt_reg <= ix;
                        if (c_reg.operation == OP_FOCUS) begin
                            for (int k = 0; k < MaxWindows; k++)
                                sf_reg[k][1] <= (SlotW'(k) == ix);
                        end
                        state_reg <= S_SHIFT;
                    end else begin
                        i_reg <= i_reg + 1'b1;
                    end
                end
                S_SHIFT: begin
                    // one slot moves down each cycle; held copy goes on top, or is dropped on destroy
                    if (ix == tgt_reg) begin
                        sv_id_reg <= sid_reg[ix];
                        sv_x_reg <= sx_reg[ix]; sv_y_reg <= sy_reg[ix];
                        sv_w_reg <= sw_reg[ix]; sv_h_reg <= sh_reg[ix];
                        sv_f_reg <= sf_reg[ix];
                    end
                    if (i_reg + 1'b1 < live_reg) begin
                        sid_reg[ix] <= sid_reg[ix+1'b1];
                        sx_reg[ix]  <= sx_reg[ix+1'b1];
                        sy_reg[ix]  <= sy_reg[ix+1'b1];
                        sw_reg[ix]  <= sw_reg[ix+1'b1];
                        sh_reg[ix]  <= sh_reg[ix+1'b1];
                        sf_reg[ix]  <= sf_reg[ix+1'b1];
                        i_reg <= i_reg + 1'b1;
                    end else begin
                        if (c_reg.operation == OP_DESTROY) begin
                            live_reg <= live_reg - 1'b1;
                        end else if (ix != tgt_reg) begin
                            sid_reg[ix] <= sv_id_reg;
                            sx_reg[ix] <= sv_x_reg; sy_reg[ix] <= sv_y_reg;
                            sw_reg[ix] <= sv_w_reg; sh_reg[ix] <= sv_h_reg;
                            sf_reg[ix] <= sv_f_reg;
                        end
                        state_reg <= S_OUT;
                    end
                end
                S_HIT: begin
                    if (hit) begin
                        st_reg    <= ST_OK;
                        rid_reg   <= sid_reg[ix];
                        hidx_reg  <= ix;
                        dx_reg    <= 12'(c_reg.pos_x - sx_reg[ix]);
                        dy_reg    <= 12'(c_reg.pos_y - sy_reg[ix]);
                        hw_reg    <= sw_reg[ix];
                        state_reg <= S_MUL;
                    end else if (i_reg == '0) begin
                        state_reg <= S_OUT;
                    end else begin
                        i_reg <= i_reg - 1'b1;
                    end
                end
                S_MUL: begin
                    offs_reg <= 24'(dy_reg) * 24'(hw_reg) + 24'(dx_reg);
                    state_reg <= S_OUT;
                end
                S_OUT: begin
                    if (!res_v_reg) begin
                        res_reg.status       <= st_reg;
                        res_reg.result_id    <= rid_reg;
                        res_reg.stack_index  <= 4'(hidx_reg);
                        res_reg.pixel_offset <= offs_reg;
                        res_reg.window_count <= 5'(live_reg);
                        res_reg.focused_id   <= foc_id;
                        res_v_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== test/wsm_checker.sv =====
module wsm_checker
    import wsm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [71:0] m_axis_tdata,
    output int          fail_count,
    output int          pending,
    output int          results_seen,
    output int          hits_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [15:0] id;
        int          x;
        int          y;
        int          w;
        int          h;
        logic        vis;
        logic        foc;
    } win_t;

    win_t        stack_q[$];
    int          next_id;
    res_t        expected_q[$];

    function automatic int find_win(logic [15:0] id);
        for (int i = 0; i < stack_q.size(); i++)
            if (stack_q[i].id == id) return i;
        return -1;
    endfunction

    function automatic logic [15:0] focus_of();
        foreach (stack_q[i]) if (stack_q[i].foc) return stack_q[i].id;
        return 16'd0;
    endfunction

    // Apply one command to the shadow stack and return its result.
    function automatic res_t apply_cmd(logic [71:0] d);
        res_t r;
        int   idx;
        int   px;
        int   py;
        win_t wv;
        logic [2:0] op;
        op = d[2:0];
        px = $signed(d[15:3]);
        py = $signed(d[28:16]);
        r = '0;
        idx = find_win(d[68:53]);
        case (op)
            OP_CREATE: begin
                if (stack_q.size() >= MaxWindows) begin
                    r.status = ST_FULL;
                end else begin
                    wv.id = next_id[15:0]; wv.x = px; wv.y = py;
                    wv.w = d[40:29]; wv.h = d[52:41]; wv.vis = 1'b1; wv.foc = 1'b0;
                    stack_q.push_back(wv);
                    r.result_id = next_id[15:0];
                    next_id = (next_id >= 65535) ? 1 : next_id + 1;
                end
            end
            OP_RAISE, OP_FOCUS: begin
                if (idx < 0) begin
                    r.status = ST_MISS;
                end else begin
                    if (op == OP_FOCUS)
                        foreach (stack_q[i]) stack_q[i].foc = 1'b0;
                    wv = stack_q[idx];
                    if (op == OP_FOCUS) wv.foc = 1'b1;
                    stack_q.delete(idx);
                    stack_q.push_back(wv);
                end
            end
            OP_UNFOCUS: foreach (stack_q[i]) stack_q[i].foc = 1'b0;
            OP_DESTROY: begin
                if (idx < 0) r.status = ST_MISS;
                else stack_q.delete(idx);
            end
            OP_HIT: begin
                r.status = ST_MISS;
                for (int i = stack_q.size() - 1; i >= 0; i--) begin
                    wv = stack_q[i];
                    if (wv.vis && px >= wv.x && px < wv.x + wv.w &&
                        py >= wv.y && py < wv.y + wv.h) begin
                        r.status = ST_OK;
                        r.result_id = wv.id;
                        r.stack_index = i[3:0];
                        r.pixel_offset = 24'((py - wv.y) * wv.w + (px - wv.x));
                        break;
                    end
                end
            end
            default: ;
        endcase
        r.window_count = 5'(stack_q.size());
        r.focused_id = focus_of();
        return r;
    endfunction

    assign pending = expected_q.size();

    always @(posedge aclk) begin
        res_t got;
        res_t want;
        res_t pred;
        if (!aresetn) begin
            stack_q.delete();
            expected_q.delete();
            next_id = 1;
            fail_count <= 0;
            results_seen <= 0;
            hits_seen <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                pred = apply_cmd(s_axis_tdata);
                expected_q.push_back(pred);
                if (s_axis_tdata[2:0] == OP_HIT && pred.status == ST_OK)
                    hits_seen <= hits_seen + 1;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.status       = m_axis_tdata[1:0];
                got.result_id    = m_axis_tdata[17:2];
                got.stack_index  = m_axis_tdata[21:18];
                got.pixel_offset = m_axis_tdata[45:22];
                got.window_count = m_axis_tdata[50:46];
                got.focused_id   = m_axis_tdata[66:51];
                results_seen <= results_seen + 1;
                if (expected_q.size() == 0) begin
                    if (fail_count < 10) $display("unexpected result %h", got);
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_q.pop_front();
                    if (got !== want || m_axis_tdata[71:67] !== '0) begin
                        if (fail_count < 10) begin
                            $display("mismatch: exp st=%0d id=%0d idx=%0d off=%0d cnt=%0d foc=%0d",
                                want.status, want.result_id, want.stack_index,
                                want.pixel_offset, want.window_count, want.focused_id);
                            $display("          got st=%0d id=%0d idx=%0d off=%0d cnt=%0d foc=%0d",
                                got.status, got.result_id, got.stack_index,
                                got.pixel_offset, got.window_count, got.focused_id);
                        end
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule

// ===== test/tb_window_stack_manager_core.sv =====
module tb_window_stack_manager_core;
    import wsm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RandItems = 1750;
    localparam int StallLimit = 20000;

    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [71:0] m_axis_tdata;

    int fail_count;
    int pending;
    int results_seen;
    int hits_seen;
    int idle_cycles;
    bit quiet_phase;   // no idling on either side in the final stretch
    bit hold_sink;     // long receiver hold-off request
    logic [15:0] recent_ids[$];

    window_stack_manager_core uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    wsm_checker chk (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .fail_count(fail_count), .pending(pending),
        .results_seen(results_seen), .hits_seen(hits_seen)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Watchdog: cycles with no handshake on either channel.
    always @(posedge aclk) begin
        if (!aresetn || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= StallLimit) begin
            $display("watchdog: no progress, pending=%0d", pending);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Track live ids from results so raise/focus/destroy mostly hit something.
    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready && m_axis_tdata[1:0] == ST_OK
            && m_axis_tdata[17:2] != 16'd0) begin
            recent_ids.push_back(m_axis_tdata[17:2]);
            if (recent_ids.size() > 24) recent_ids.delete(0);
        end
    end

    // Receiver: random bursts of backpressure, plus one long hold.
    initial begin
        int hold;
        m_axis_tready <= 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_sink) begin
                m_axis_tready <= 1'b0;
                hold = 0;
                while (hold < 300) begin
                    @(posedge aclk);
                    hold++;
                end
                hold_sink = 1'b0;
            end else if (!quiet_phase && $urandom_range(0, 3) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge aclk);
            end else begin
                m_axis_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // Build a command item; ids drawn mostly from windows seen in results.
    function automatic logic [71:0] pack_cmd(logic [2:0] op, logic [12:0] x, logic [12:0] y,
                                             logic [11:0] w, logic [11:0] h, logic [15:0] id);
        return {3'b000, id, h, w, y, x, op};
    endfunction

    function automatic logic [15:0] pick_id();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 16'($urandom);
        if (r == 1) return 16'd0;
        if (recent_ids.size() == 0) return 16'd1;
        return recent_ids[$urandom_range(0, recent_ids.size() - 1)];
    endfunction

    task automatic send(logic [71:0] d);
        if (!quiet_phase && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= d;
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
    endtask

    task automatic send_random();
        int          r;
        logic [2:0]  op;
        logic [12:0] x;
        logic [12:0] y;
        logic [11:0] w;
        logic [11:0] h;
        r = $urandom_range(0, 99);
        if (r < 25) op = OP_CREATE;
        else if (r < 35) op = OP_RAISE;
        else if (r < 45) op = OP_FOCUS;
        else if (r < 49) op = OP_UNFOCUS;
        else if (r < 62) op = OP_DESTROY;
        else if (r < 97) op = OP_HIT;
        else op = 3'($urandom_range(6, 7));
        // Mostly a small screen so windows overlap and points land inside.
        if ($urandom_range(0, 4) == 0) begin
            x = 13'($urandom); y = 13'($urandom);
            w = 12'($urandom); h = 12'($urandom);
        end else begin
            x = 13'($signed($urandom_range(0, 200)) - 100);
            y = 13'($signed($urandom_range(0, 200)) - 100);
            w = 12'($urandom_range(0, 120));
            h = 12'($urandom_range(0, 120));
        end
        send(pack_cmd(op, x, y, w, h, pick_id()));
    endtask

    initial begin
        int n;
        aresetn = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        quiet_phase = 1'b0;
        hold_sink = 1'b0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty-stack misses, extremes, full table, every operation.
        send(pack_cmd(OP_HIT, 13'd0, 13'd0, 12'd0, 12'd0, 16'd0));
        send(pack_cmd(OP_RAISE, 13'd0, 13'd0, 12'd0, 12'd0, 16'd1));
        send(pack_cmd(OP_CREATE, 13'h1000, 13'h1000, 12'hFFF, 12'hFFF, 16'hFFFF));
        send(pack_cmd(OP_HIT, 13'h0FFF, 13'h0FFF, 12'd0, 12'd0, 16'd0));
        send(pack_cmd(OP_HIT, 13'h1000, 13'h1000, 12'd0, 12'd0, 16'd0));
        send(pack_cmd(OP_CREATE, 13'd5, 13'd5, 12'd0, 12'd10, 16'd0)); // zero width
        send(pack_cmd(OP_HIT, 13'd5, 13'd5, 12'd0, 12'd0, 16'd0));
        for (int i = 0; i < 15; i++) begin
            send(pack_cmd(OP_CREATE, 13'(i), 13'(i), 12'd20, 12'd20, 16'd0));
        end
        send(pack_cmd(OP_FOCUS, 13'd0, 13'd0, 12'd0, 12'd0, 16'd1));
        send(pack_cmd(OP_HIT, 13'd10, 13'd10, 12'd0, 12'd0, 16'd0));
        send(pack_cmd(OP_UNFOCUS, 13'd0, 13'd0, 12'd0, 12'd0, 16'd0));
        send(pack_cmd(OP_DESTROY, 13'd0, 13'd0, 12'd0, 12'd0, 16'd0));
        send(pack_cmd(OP_DESTROY, 13'd0, 13'd0, 12'd0, 12'd0, 16'd3));
        send(pack_cmd(3'd7, 13'd0, 13'd0, 12'd0, 12'd0, 16'd0));

        // Long receiver hold while commands keep coming in.
        hold_sink = 1'b1;
        for (int i = 0; i < 6; i++) send_random();

        n = 0;
        while (n < RandItems) begin
            if (n > RandItems * 9 / 10) quiet_phase = 1'b1;
            send_random();
            n++;
        end
        s_axis_tvalid <= 1'b0;

        while (pending != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
        $display("ran corner commands, a full table and a long sink stall, then %0d random ones",
                 RandItems);
        $display("%0d results compared, %0d of them hit-test hits", results_seen, hits_seen);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("%0d mismatches", fail_count);
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
